[rtl/core/assert_macros.svh]
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/adsdz_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package adsdz_pkg;

  localparam int FRAC_BITS = 12;
  localparam int OUT_RANGE = 80;
  localparam int ONE_FX    = 1 << FRAC_BITS;
  localparam int MIN_SCALE = (ONE_FX + 99) / 100;
  localparam int NSTAGE    = 7;

  localparam logic [12:0] ONE_FX_C    = 13'(ONE_FX);
  localparam logic [12:0] MIN_SCALE_C = 13'(MIN_SCALE);

  localparam logic CFG_MIN_DZ = 1'b0;
  localparam logic CFG_MAX_DZ = 1'b1;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld;
  } flow_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [12:0] root;
  } sqrt_t;

  // One digit of the square root: bring in two radicand bits.
  function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] pair);
    logic [15:0] t;
    logic [15:0] trial;
    sqrt_t       nxt;
    t     = {cur.rem[13:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (t >= trial) begin
      nxt.rem  = t - trial;
      nxt.root = {cur.root[11:0], 1'b1};
    end else begin
      nxt.rem  = t;
      nxt.root = {cur.root[11:0], 1'b0};
    end
    return nxt;
  endfunction

  // One quotient bit of the scale division, zeros shifted in.
  function automatic logic [13:0] scale_step(logic [12:0] rem, logic [12:0] den);
    logic [13:0] t;
    logic [13:0] res;
    t = {rem, 1'b0};
    if (t >= {1'b0, den}) begin
      res = {t[12:0] - den, 1'b1};
    end else begin
      res = {t[12:0], 1'b0};
    end
    return res;
  endfunction

  // One quotient bit of the axis division.
  function automatic logic [8:0] axis_step(logic [7:0] rem, logic b, logic [7:0] m);
    logic [8:0] t;
    logic [8:0] res;
    t = {rem, b};
    if (t >= {1'b0, m}) begin
      res = {8'(t - {1'b0, m}), 1'b1};
    end else begin
      res = {t[7:0], 1'b0};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/core/analog_stick_deadzone_mapper.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: raw_x, raw_y
// m_axis    out  m_axis_tvalid/tready       tdata: stick_x, stick_y
// cfg       in   cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// Seven register stages; one beat enters per cycle while the pipeline is not stalled.
// Stage depth is set by the digit-serial root and the two long divisions,
// spread at up to seven digit steps per stage.
// Each stage holds while its successor is full and stalled; bubbles close up.
// Reset clears the stage valid bits and loads the deadzone registers.
module analog_stick_deadzone_mapper import adsdz_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] raw_x, [15:8] raw_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] stick_x, [15:8] stick_y
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  flow_t flow;
  adsdz_flow u_flow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .flow_o     (flow)
  );
  assign s_axis_tready = flow.en[0];
  assign m_axis_tvalid = flow.vld[NSTAGE-1];

  // Deadzone registers.
  logic [12:0] min_dz_q, max_dz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dz_q <= 13'd1147;
      max_dz_q <= 13'(ONE_FX);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_DZ: min_dz_q <= cfg_data_i;
        CFG_MAX_DZ: max_dz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: centre, magnitudes, dominant axis, squared length.
  logic signed [7:0] cx, cy;
  logic [7:0]  ax, ay;
  assign cx = $signed(s_axis_tdata[7:0] ^ 8'h80);
  assign cy = $signed(s_axis_tdata[15:8] ^ 8'h80);
  assign ax = cx[7] ? 8'(-cx) : 8'(cx);
  assign ay = cy[7] ? 8'(-cy) : 8'(cy);

  logic        sx1_q, sy1_q;
  logic [7:0]  m1_q;
  logic [13:0] px1_q, py1_q;
  logic [15:0] sq1_q;
  always_ff @(posedge clk_i) begin
    if (flow.en[0]) begin
      sx1_q <= cx[7];
      sy1_q <= cy[7];
      m1_q  <= (ax > ay) ? ax : ay;
      px1_q <= {6'd0, ax} * 14'(OUT_RANGE);
      py1_q <= {6'd0, ay} * 14'(OUT_RANGE);
      sq1_q <= {8'd0, ax} * {8'd0, ax} + {8'd0, ay} * {8'd0, ay};
    end
  end

  // Stage 2: root digits from the top seven radicand pairs.
  sqrt_t rt2;
  always_comb begin
    rt2 = '0;
    for (int k = 0; k < 7; k++) begin
      rt2 = sqrt_step(rt2, sq1_q[15-2*k -: 2]);
    end
  end

  logic        sx2_q, sy2_q;
  logic [7:0]  m2_q;
  logic [13:0] px2_q, py2_q;
  logic [1:0]  low2_q;
  sqrt_t       rt2_q;
  always_ff @(posedge clk_i) begin
    if (flow.en[1]) begin
      sx2_q <= sx1_q; sy2_q <= sy1_q; m2_q <= m1_q;
      px2_q <= px1_q; py2_q <= py1_q;
      low2_q <= sq1_q[1:0];
      rt2_q <= rt2;
    end
  end

  // Stage 3: remaining six digits; the last radicand pair, then zero pairs.
  sqrt_t rt3;
  always_comb begin
    rt3 = sqrt_step(rt2_q, low2_q);
    for (int k = 0; k < 5; k++) begin
      rt3 = sqrt_step(rt3, 2'b00);
    end
  end

  logic        sx3_q, sy3_q;
  logic [7:0]  m3_q;
  logic [13:0] px3_q, py3_q;
  logic [12:0] r3_q;
  always_ff @(posedge clk_i) begin
    if (flow.en[2]) begin
      sx3_q <= sx2_q; sy3_q <= sy2_q; m3_q <= m2_q;
      px3_q <= px2_q; py3_q <= py2_q;
      r3_q  <= rt3.root;
    end
  end

  // Stage 4: band checks, first six scale bits.
  logic [12:0] diff4, den4;
  logic        dead4, sat4;
  logic [12:0] rem4;
  logic [5:0]  q4;
  logic [13:0] st4;
  always_comb begin
    diff4 = r3_q - min_dz_q;
    den4  = max_dz_q - min_dz_q;
    dead4 = r3_q < min_dz_q;
    sat4  = (max_dz_q <= min_dz_q) || (diff4 >= den4);
    rem4  = diff4;
    q4    = '0;
    for (int k = 0; k < 6; k++) begin
      st4  = scale_step(rem4, den4);
      rem4 = st4[13:1];
      q4   = {q4[4:0], st4[0]};
    end
  end

  logic        sx4_q, sy4_q, dead4_q, sat4_q;
  logic [7:0]  m4_q;
  logic [13:0] px4_q, py4_q;
  logic [12:0] rem4_q, den4_q;
  logic [5:0]  q4_q;
  always_ff @(posedge clk_i) begin
    if (flow.en[3]) begin
      sx4_q <= sx3_q; sy4_q <= sy3_q; m4_q <= m3_q;
      px4_q <= px3_q; py4_q <= py3_q;
      dead4_q <= dead4; sat4_q <= sat4;
      rem4_q <= rem4; den4_q <= den4; q4_q <= q4;
    end
  end

  // Stage 5: last six scale bits, clamp, zero decision.
  logic [12:0] rem5, s5;
  logic [11:0] q5;
  logic [13:0] st5;
  always_comb begin
    rem5 = rem4_q;
    q5   = {q4_q, 6'd0};
    for (int k = 0; k < 6; k++) begin
      st5  = scale_step(rem5, den4_q);
      rem5 = st5[13:1];
      q5   = {q5[11:6], q5[4:0], st5[0]};
    end
    s5 = sat4_q ? ONE_FX_C : {1'b0, q5};
  end

  logic        sx5_q, sy5_q, zero5_q;
  logic [7:0]  m5_q;
  logic [13:0] px5_q, py5_q;
  logic [12:0] s5_q;
  always_ff @(posedge clk_i) begin
    if (flow.en[4]) begin
      sx5_q <= sx4_q; sy5_q <= sy4_q; m5_q <= m4_q;
      px5_q <= px4_q; py5_q <= py4_q;
      s5_q  <= s5;
      zero5_q <= dead4_q || (s5 < MIN_SCALE_C) || (m4_q == 8'd0);
    end
  end

  // Stage 6: scale the axis products, drop the fraction.
  logic [26:0] nx6, ny6;
  assign nx6 = px5_q * s5_q;
  assign ny6 = py5_q * s5_q;

  logic        sx6_q, sy6_q, zero6_q;
  logic [7:0]  m6_q;
  logic [13:0] nx6_q, ny6_q;
  always_ff @(posedge clk_i) begin
    if (flow.en[5]) begin
      sx6_q <= sx5_q; sy6_q <= sy5_q; zero6_q <= zero5_q; m6_q <= m5_q;
      nx6_q <= nx6[25:12];
      ny6_q <= ny6[25:12];
    end
  end

  // Stage 7: divide by the dominant axis, apply signs, invert y.
  logic [7:0] rx7, ry7;
  logic [6:0] qx7, qy7;
  logic [8:0] tx7, ty7;
  logic [7:0] ox7, oy7;
  always_comb begin
    rx7 = {1'b0, nx6_q[13:7]};
    ry7 = {1'b0, ny6_q[13:7]};
    qx7 = '0;
    qy7 = '0;
    for (int k = 6; k >= 0; k--) begin
      tx7 = axis_step(rx7, nx6_q[k], m6_q);
      ty7 = axis_step(ry7, ny6_q[k], m6_q);
      rx7 = tx7[8:1];
      ry7 = ty7[8:1];
      qx7[k] = tx7[0];
      qy7[k] = ty7[0];
    end
    if (zero6_q) begin
      ox7 = '0;
      oy7 = '0;
    end else begin
      ox7 = sx6_q ? 8'(-{1'b0, qx7}) : {1'b0, qx7};
      oy7 = sy6_q ? {1'b0, qy7} : 8'(-{1'b0, qy7});
    end
  end

  logic [15:0] out_q;
  always_ff @(posedge clk_i) begin
    if (flow.en[6]) begin
      out_q <= {oy7, ox7};
    end
  end
  assign m_axis_tdata = out_q;

endmodule
`default_nettype wire

[rtl/core/adsdz_flow.sv]
`timescale 1ns / 1ps
`default_nettype none
module adsdz_flow import adsdz_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_ready_i,
  output flow_t flow_o
);
  `include "assert_macros.svh"

  logic [NSTAGE-1:0] vld_q, vld_d;
  logic [NSTAGE-1:0] en;

  // Stage advances when empty or when the one after it advances.
  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) vld_d[0] = in_valid_i;
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign flow_o.en  = en;
  assign flow_o.vld = vld_q;

  `ASSERT_SAME(a_full_blocks, (&vld_q) && !out_ready_i, !en[0])
  `ASSERT_NEXT(a_accept_fills, in_valid_i && en[0], vld_q[0])
  `ASSERT_NEXT(a_held_result, !en[NSTAGE-1], vld_q[NSTAGE-1])

endmodule
`default_nettype wire
